@@ rtl/core/sha256s_pkg.sv @@
// shared types and constants of the sha-256 stream hasher
package sha256s_pkg;

  localparam int unsigned NumRounds = 64;
  localparam int unsigned BlockBytes = 64;

  typedef enum logic [1:0] {
    BYTE_IN,
    BYTE_PAD,
    BYTE_ZERO,
    BYTE_LEN
  } byte_sel_e;

  // commands from controller to datapath
  typedef struct packed {
    logic      push;
    byte_sel_e sel;
    logic      count_inc;
    logic      load;
    logic      round;
    logic [5:0] rnd_idx;
    logic      add;
    logic      init;
    logic [2:0] len_idx;
    logic [2:0] out_idx;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [5:0] fill;
  } status_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LEN_OFFSET = 6'd56;

endpackage

@@ rtl/core/sha256s_if.sv @@
// stream interfaces for message bytes and digest words
interface sha256s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       message_end;
  modport source (output valid, data_byte, byte_present, message_end, input ready);
  modport sink (input valid, data_byte, byte_present, message_end, output ready);
endinterface

interface sha256s_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

@@ rtl/core/sha256s_datapath.sv @@
// block buffer, message schedule, round logic and hash state
module sha256s_datapath import sha256s_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [7:0]  data_byte_i,
  output status_t     status_o,
  output logic [31:0] digest_word_o
);

  logic [511:0]      blk_q, blk_d;
  logic [7:0][31:0]  v_q, v_d;
  logic [31:0]       h_q [8];
  logic [5:0]        fill_q;
  logic [60:0]       count_q;
  logic [63:0]       bits;
  logic [7:0]        push_val;
  logic [31:0]       w0, w1, w9, w14, s0, s1, wnew;
  logic [31:0]       a, e, big0, big1, ch, maj, t1, t2;

  // byte to append
  assign bits = {count_q, 3'b000};
  always_comb begin
    case (cmd_i.sel)
      BYTE_IN:   push_val = data_byte_i;
      BYTE_PAD:  push_val = PAD_BYTE;
      BYTE_ZERO: push_val = 8'h00;
      default:   push_val = bits[6'(63 - 8 * int'(cmd_i.len_idx)) -: 8];
    endcase
  end

  // schedule taps
  assign w0   = blk_q[511:480];
  assign w1   = blk_q[479:448];
  assign w9   = blk_q[223:192];
  assign w14  = blk_q[63:32];
  assign s0   = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
  assign s1   = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
  assign wnew = w0 + s0 + w9 + s1;

  // round function
  assign a    = v_q[0];
  assign e    = v_q[4];
  assign big1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
  assign ch   = (e & v_q[5]) ^ (~e & v_q[6]);
  assign t1   = v_q[7] + big1 + ch + K_TAB[cmd_i.rnd_idx] + w0;
  assign big0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
  assign maj  = (a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]);
  assign t2   = big0 + maj;

  always_comb begin
    blk_d = blk_q;
    if (cmd_i.push) begin
      blk_d = {blk_q[503:0], push_val};
    end else if (cmd_i.round) begin
      blk_d = {blk_q[479:0], wnew};
    end
  end

  always_comb begin
    v_d = v_q;
    if (cmd_i.load) begin
      for (int i = 0; i < 8; i++) begin
        v_d[i] = h_q[i];
      end
    end else if (cmd_i.round) begin
      v_d[7] = v_q[6];
      v_d[6] = v_q[5];
      v_d[5] = v_q[4];
      v_d[4] = v_q[3] + t1;
      v_d[3] = v_q[2];
      v_d[2] = v_q[1];
      v_d[1] = v_q[0];
      v_d[0] = t1 + t2;
    end
  end

  // buffer and working variables
  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
    v_q   <= v_d;
  end

  // hash words and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= H_INIT[i];
      end
      fill_q  <= '0;
      count_q <= '0;
    end else begin
      if (cmd_i.init) begin
        for (int i = 0; i < 8; i++) begin
          h_q[i] <= H_INIT[i];
        end
        fill_q  <= '0;
        count_q <= '0;
      end else begin
        if (cmd_i.add) begin
          for (int i = 0; i < 8; i++) begin
            h_q[i] <= h_q[i] + v_q[i];
          end
        end
        if (cmd_i.push) begin
          fill_q <= fill_q + 6'd1;
        end
        if (cmd_i.count_inc) begin
          count_q <= count_q + 61'd1;
        end
      end
    end
  end

  assign status_o.fill = fill_q;
  assign digest_word_o = h_q[cmd_i.out_idx];

endmodule

@@ rtl/core/sha256s_ctrl.sv @@
// sequencer for absorb, padding, compression rounds and digest output
module sha256s_ctrl import sha256s_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  input  logic    byte_present_i,
  input  logic    message_end_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_ZERO, S_LEN, S_LOAD, S_RND, S_ADD, S_OUT
  } state_e;

  state_e     state_q, ret_q;
  logic [5:0] round_q;
  logic [2:0] len_q;
  logic [2:0] idx_q;
  logic       acc;
  logic       full;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign acc         = in_valid_i & in_ready_o;
  assign full        = (status_i.fill == 6'd63);

  // command decode
  always_comb begin
    cmd_o = '0;
    cmd_o.sel     = BYTE_IN;
    cmd_o.rnd_idx = round_q;
    cmd_o.len_idx = len_q;
    cmd_o.out_idx = idx_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.push      = acc & byte_present_i;
        cmd_o.count_inc = acc & byte_present_i;
      end
      S_PAD: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = BYTE_PAD;
      end
      S_ZERO: begin
        cmd_o.push = (status_i.fill != LEN_OFFSET);
        cmd_o.sel  = BYTE_ZERO;
      end
      S_LEN: begin
        cmd_o.push = 1'b1;
        cmd_o.sel  = BYTE_LEN;
      end
      S_LOAD: cmd_o.load = 1'b1;
      S_RND:  cmd_o.round = 1'b1;
      S_ADD:  cmd_o.add = 1'b1;
      S_OUT:  cmd_o.init = out_ready_i & (idx_q == 3'd7);
      default: ;
    endcase
  end

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      round_q <= '0;
      len_q   <= '0;
      idx_q   <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (acc) begin
            if (byte_present_i && full) begin
              state_q <= S_LOAD;
              ret_q   <= message_end_i ? S_PAD : S_IDLE;
            end else if (message_end_i) begin
              state_q <= S_PAD;
            end
          end
        end
        S_PAD: begin
          if (full) begin
            state_q <= S_LOAD;
            ret_q   <= S_ZERO;
          end else begin
            state_q <= S_ZERO;
          end
        end
        S_ZERO: begin
          if (status_i.fill == LEN_OFFSET) begin
            state_q <= S_LEN;
            len_q   <= '0;
          end else if (full) begin
            state_q <= S_LOAD;
            ret_q   <= S_ZERO;
          end
        end
        S_LEN: begin
          len_q <= len_q + 3'd1;
          if (len_q == 3'd7) begin
            state_q <= S_LOAD;
            ret_q   <= S_OUT;
            idx_q   <= '0;
          end
        end
        S_LOAD: begin
          round_q <= '0;
          state_q <= S_RND;
        end
        S_RND: begin
          round_q <= round_q + 6'd1;
          if (round_q == 6'd63) begin
            state_q <= S_ADD;
          end
        end
        S_ADD: state_q <= ret_q;
        S_OUT: begin
          if (out_ready_i) begin
            idx_q <= idx_q + 3'd1;
            if (idx_q == 3'd7) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/sha256_stream_hasher_core.sv @@
// sha-256 over a byte stream: one byte per transfer, eight digest words per message
// an item with only a byte keeps the input ready; one that fills the block adds
// a compression (load, 64 rounds on a single round unit, add); an end item runs
// padding one byte per cycle plus one or two compressions, then 8 digest transfers
// reset is asynchronous, active low, and restores the initial hash and zero counts
module sha256_stream_hasher_core import sha256s_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  sha256s_in_if.sink    in_s,
  sha256s_out_if.source out_s
);

  cmd_t        cmd;
  status_t     status;
  logic [31:0] digest;

  sha256s_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_s.valid),
    .byte_present_i (in_s.byte_present),
    .message_end_i  (in_s.message_end),
    .in_ready_o     (in_s.ready),
    .out_valid_o    (out_s.valid),
    .out_ready_i    (out_s.ready),
    .status_i       (status),
    .cmd_o          (cmd)
  );

  sha256s_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .data_byte_i   (in_s.data_byte),
    .status_o      (status),
    .digest_word_o (digest)
  );

  assign out_s.digest_word = digest;
  assign out_s.word_index  = cmd.out_idx;
  assign out_s.last_word   = (cmd.out_idx == 3'd7);

endmodule

@@ test/sha256s_checker.sv @@
// checker for the sha-256 stream hasher: watches both channels and compares digests
`timescale 1ns / 1ps
module sha256s_checker import sha256s_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_byte_i,
  input  logic        in_present_i,
  input  logic        in_end_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [31:0] out_word_i,
  input  logic [2:0]  out_index_i,
  input  logic        out_last_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          digests_o
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_beat_t;

  logic [31:0] hash_state [8];
  logic [7:0]  block_bytes [64];
  logic [5:0]  fill;
  logic [60:0] msg_bytes;
  digest_beat_t digest_queue [$];

  function automatic logic [31:0] ror(logic [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  // one compression of the current block into the hash state
  task automatic run_block();
    logic [31:0] w [16];
    logic [31:0] v [8];
    logic [31:0] x15, x2, wr, t1, t2;
    for (int j = 0; j < 16; j++)
      w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
    v = hash_state;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        x15 = w[(r - 15) & 15];
        x2 = w[(r - 2) & 15];
        wr = w[r & 15] + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[(r - 7) & 15]
             + (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10));
        w[r & 15] = wr;
      end
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[r] + wr;
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] += v[j];
  endtask

  task automatic append_byte(logic [7:0] b);
    block_bytes[fill] = b;
    fill++;
    if (fill == 0) run_block();
  endtask

  task automatic restart_message();
    hash_state = H_INIT;
    fill = '0;
    msg_bytes = '0;
  endtask

  // model one accepted input transfer
  task automatic absorb_item(logic [7:0] b, logic present, logic fin);
    logic [63:0] bits;
    if (present) begin
      msg_bytes++;
      append_byte(b);
    end
    if (fin) begin
      bits = {msg_bytes, 3'b000};
      append_byte(PAD_BYTE);
      while (fill != LEN_OFFSET) append_byte(8'h00);
      for (int i = 0; i < 8; i++) append_byte(bits[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++)
        digest_queue.push_back('{hash_state[i], 3'(i), i == 7});
      restart_message();
    end
  endtask

  // predict on input transfers, compare on output transfers
  always @(posedge clk_i) begin
    digest_beat_t exp_beat;
    if (!rst_ni) begin
      restart_message();
    end else begin
      if (in_valid_i && in_ready_i) absorb_item(in_byte_i, in_present_i, in_end_i);
      if (out_valid_i && out_ready_i) begin
        if (out_last_i) digests_o++;
        if (digest_queue.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("unexpected digest word %h index %0d", out_word_i, out_index_i);
        end else begin
          exp_beat = digest_queue.pop_front();
          if (exp_beat.word !== out_word_i || exp_beat.index !== out_index_i ||
              exp_beat.last !== out_last_i) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("mismatch: expected %h/%0d/%b got %h/%0d/%b", exp_beat.word,
                       exp_beat.index, exp_beat.last, out_word_i, out_index_i, out_last_i);
          end
        end
      end
    end
    pending_o = digest_queue.size();
  end

endmodule

@@ test/tb_top.sv @@
// top of the sha-256 stream hasher testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_top;

  localparam int CycleLimit = 2000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending, digests;
  int   idle_pct, stall_pct, cycles, items_sent;
  bit   hold_off;

  sha256s_in_if  in_ch();
  sha256s_out_if out_ch();

  sha256_stream_hasher_core dut (.clk_i(clk_i), .rst_ni(rst_ni), .in_s(in_ch), .out_s(out_ch));

  sha256s_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_ch.valid), .in_ready_i(in_ch.ready), .in_byte_i(in_ch.data_byte),
    .in_present_i(in_ch.byte_present), .in_end_i(in_ch.message_end),
    .out_valid_i(out_ch.valid), .out_ready_i(out_ch.ready), .out_word_i(out_ch.digest_word),
    .out_index_i(out_ch.word_index), .out_last_i(out_ch.last_word),
    .fail_count_o(fail_count), .pending_o(pending), .digests_o(digests)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // cycle limit guard
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver with random stalls and a long hold-off window
  initial out_ch.ready = 1'b0;
  always @(negedge clk_i) begin
    out_ch.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // one input transfer, with random idle cycles before it
  task automatic send_item(logic [7:0] b, logic present, logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.byte_present <= present;
    in_ch.message_end <= fin;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic send_message(int len, int mode);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = (mode == 1) ? 8'h00 : (mode == 2) ? 8'hff : 8'($urandom);
      if ($urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && $urandom_range(1)) begin
        send_item(b, 1'b1, 1'b1);
        return;
      end
      send_item(b, 1'b1, 1'b0);
    end
    send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (300) @(negedge clk_i);
  endtask

  initial begin
    int len, base;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.byte_present = 1'b0;
    in_ch.message_end = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty message, idle item, extreme bytes, padding boundaries
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h00, 1'b1, 1'b1);
    send_message(3, 2);
    send_message(2, 1);
    drain();
    send_message(55, 0);
    send_message(56, 2);
    send_message(64, 0);
    drain();

    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 15 : 69) : 0;
      stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 15 : 69) : 0;
      base = items_sent;
      while (items_sent < base + 60) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(130, 56) : $urandom_range(12);
        send_message(len, 0);
      end
      if (ph == 0) begin
        // long receiver hold-off while short messages keep coming
        fork
          begin
            hold_off = 1'b1;
            repeat (400) @(negedge clk_i);
            hold_off = 1'b0;
          end
          repeat (6) send_message($urandom_range(2), 0);
        join
      end
    end
    drain();

    $display("covered %0d input items and %0d digests, with empty, padding-boundary",
             items_sent, digests);
    $display("and multi-block messages under sender idling and receiver stalls");
    if (fail_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
